// File: rtl/ugpb_pkg.sv
// Shared types, codes and defaults for the uniform grid point binning block.
`default_nettype none

package ugpb_pkg;

  // Default grid dimensions and count width.
  localparam int GRID_X_DEF     = 32;
  localparam int GRID_Y_DEF     = 32;
  localparam int GRID_Z_DEF     = 32;
  localparam int COUNT_BITS_DEF = 32;

  // Fixed sizes of the item fields.
  localparam int STORE_DEPTH = 32768;
  localparam int CELL_IDX_W  = 15;
  localparam int POS_W       = 32;
  localparam int CNT_OUT_W   = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Command codes.
  localparam logic [1:0] CMD_ADD        = 2'd0;
  localparam logic [1:0] CMD_READ       = 2'd1;
  localparam logic [1:0] CMD_READ_CLEAR = 2'd2;
  localparam logic [1:0] CMD_READ_ALT   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_Z = 3'd5;

  // Reset value of the cell size reciprocals (1.0 in Q16.16).
  localparam logic [CFG_DATA_W-1:0] INV_CELL_RST = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]            command;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [CELL_IDX_W-1:0] read_cell;
  } in_item_t;

  typedef struct packed {
    logic [CELL_IDX_W-1:0] cell_index;
    logic [CNT_OUT_W-1:0]  cell_count;
    logic                  out_of_range;
  } out_item_t;

  // Axes are walked z, y, x so that the linear index builds up Horner style.
  typedef enum logic [1:0] {
    AX_Z,
    AX_Y,
    AX_X
  } axis_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUB,
    ST_MUL,
    ST_CHK,
    ST_ADDR,
    ST_READ,
    ST_COMMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  clr_step;
    logic  load;
    axis_t axis;
    logic  sub_en;
    logic  mul_en;
    logic  chk_en;
    logic  addr_en;
    logic  commit;
  } bin_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic new_is_add;
    logic out_free;
  } bin_sts_t;

endpackage

`default_nettype wire

// File: rtl/ugpb_ctrl.sv
// Controller state machine that sequences clearing, axis steps and count updates.
`default_nettype none

module ugpb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output ugpb_pkg::bin_cmd_t     cmd,
  input  wire ugpb_pkg::bin_sts_t sts
);
  import ugpb_pkg::*;

  state_t state_r, state_nxt;
  axis_t  axis_r, axis_nxt;

  // State and axis registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      axis_r  <= AX_Z;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          axis_nxt = AX_Z;
          state_nxt = sts.new_is_add ? ST_SUB : ST_READ;
        end
      end
      ST_SUB: begin
        cmd.sub_en = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_CHK;
      end
      ST_CHK: begin
        cmd.chk_en = 1'b1;
        unique case (axis_r)
          AX_Z: begin
            axis_nxt  = AX_Y;
            state_nxt = ST_SUB;
          end
          AX_Y: begin
            axis_nxt  = AX_X;
            state_nxt = ST_SUB;
          end
          default: begin
            state_nxt = ST_ADDR;
          end
        endcase
      end
      ST_ADDR: begin
        cmd.addr_en = 1'b1;
        state_nxt   = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/ugpb_dpath.sv
// Datapath: configuration, axis arithmetic, count memory and result register.
`default_nettype none

module ugpb_dpath #(
  parameter int GRID_X     = ugpb_pkg::GRID_X_DEF,
  parameter int GRID_Y     = ugpb_pkg::GRID_Y_DEF,
  parameter int GRID_Z     = ugpb_pkg::GRID_Z_DEF,
  parameter int COUNT_BITS = ugpb_pkg::COUNT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ugpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ugpb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire ugpb_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output ugpb_pkg::out_item_t                   out_data,
  input  wire ugpb_pkg::bin_cmd_t               cmd,
  output ugpb_pkg::bin_sts_t                    sts
);
  import ugpb_pkg::*;

  localparam int TOTAL     = GRID_X * GRID_Y * GRID_Z;
  localparam int MEM_DEPTH = (TOTAL > STORE_DEPTH) ? STORE_DEPTH : TOTAL;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int ACC_W     = $clog2(TOTAL + 1);

  localparam logic [POS_W-1:0] SIZE_X = POS_W'(GRID_X);
  localparam logic [POS_W-1:0] SIZE_Y = POS_W'(GRID_Y);
  localparam logic [POS_W-1:0] SIZE_Z = POS_W'(GRID_Z);
  localparam logic [ACC_W-1:0] MUL_X  = ACC_W'(GRID_X);
  localparam logic [ACC_W-1:0] MUL_Y  = ACC_W'(GRID_Y);
  localparam logic [ACC_W-1:0] ACC_DEPTH = ACC_W'(MEM_DEPTH);
  localparam logic [CELL_IDX_W:0] RD_DEPTH = (CELL_IDX_W + 1)'(MEM_DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(MEM_DEPTH - 1);

  // Configuration registers.
  logic signed [POS_W-1:0] origin_x_r, origin_y_r, origin_z_r;
  logic [POS_W-1:0]        inv_x_r, inv_y_r, inv_z_r;

  // Item registers.
  logic [1:0]              cmd_r;
  logic signed [POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [POS_W-1:0]        mag_r;
  logic                    neg_r;
  logic [2*POS_W-1:0]      prod_r;
  logic                    bad_r;
  logic [ACC_W-1:0]        acc_r;
  logic [CELL_IDX_W-1:0]   cidx_r;
  logic                    hit_r;

  // Count memory and clearing sweep.
  logic [COUNT_BITS-1:0] mem [MEM_DEPTH];
  logic [COUNT_BITS-1:0] rdata_r;
  logic [AW-1:0]         clr_addr_r;

  logic                  out_valid_r;
  out_item_t             out_data_r;

  // Combinational helpers.
  logic signed [POS_W-1:0] pos_sel, org_sel;
  logic [POS_W-1:0]        inv_sel, size_sel;
  logic [ACC_W-1:0]        mul_sel;
  logic [POS_W:0]          diff_fwd, diff_rev;
  logic                    diff_neg;
  logic [POS_W-1:0]        mag_nxt;
  logic                    axis_bad;
  logic [ACC_W-1:0]        acc_nxt;
  logic                    is_add, is_clear, cnt_max, rd_hit;
  logic [COUNT_BITS-1:0]   cnt_inc;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [COUNT_BITS-1:0]   mem_wdata;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
      inv_x_r    <= INV_CELL_RST;
      inv_y_r    <= INV_CELL_RST;
      inv_z_r    <= INV_CELL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:   origin_x_r <= cfg_wdata;
        CFG_ORIGIN_Y:   origin_y_r <= cfg_wdata;
        CFG_ORIGIN_Z:   origin_z_r <= cfg_wdata;
        CFG_INV_CELL_X: inv_x_r    <= cfg_wdata;
        CFG_INV_CELL_Y: inv_y_r    <= cfg_wdata;
        CFG_INV_CELL_Z: inv_z_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Per-axis operand selection.
  always_comb begin
    unique case (cmd.axis)
      AX_Z: begin
        pos_sel  = pos_z_r;
        org_sel  = origin_z_r;
        inv_sel  = inv_z_r;
        size_sel = SIZE_Z;
        mul_sel  = '0;
      end
      AX_Y: begin
        pos_sel  = pos_y_r;
        org_sel  = origin_y_r;
        inv_sel  = inv_y_r;
        size_sel = SIZE_Y;
        mul_sel  = MUL_Y;
      end
      default: begin
        pos_sel  = pos_x_r;
        org_sel  = origin_x_r;
        inv_sel  = inv_x_r;
        size_sel = SIZE_X;
        mul_sel  = MUL_X;
      end
    endcase
  end

  // Both differences in parallel; the magnitude always fits in 32 bits.
  assign diff_fwd = {pos_sel[POS_W-1], pos_sel} - {org_sel[POS_W-1], org_sel};
  assign diff_rev = {org_sel[POS_W-1], org_sel} - {pos_sel[POS_W-1], pos_sel};
  assign diff_neg = diff_fwd[POS_W];
  assign mag_nxt  = diff_neg ? diff_rev[POS_W-1:0] : diff_fwd[POS_W-1:0];

  // A negative offset is in the grid only when the product is exactly zero.
  assign axis_bad = neg_r ? (prod_r != '0) : (prod_r[2*POS_W-1:POS_W] >= size_sel);
  assign acc_nxt  = acc_r * mul_sel + prod_r[POS_W +: ACC_W];

  assign is_add   = (cmd_r == CMD_ADD);
  assign is_clear = (cmd_r == CMD_READ_CLEAR);
  assign cnt_max  = &rdata_r;
  assign cnt_inc  = cnt_max ? rdata_r : rdata_r + 1'b1;
  assign rd_hit   = ({1'b0, in_data.read_cell} < RD_DEPTH);

  // Item registers and axis steps.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_data.command;
      pos_x_r <= in_data.pos_x;
      pos_y_r <= in_data.pos_y;
      pos_z_r <= in_data.pos_z;
      bad_r   <= 1'b0;
      acc_r   <= '0;
      cidx_r  <= in_data.read_cell;
      hit_r   <= rd_hit;
    end
    if (cmd.sub_en) begin
      mag_r <= mag_nxt;
      neg_r <= diff_neg;
    end
    if (cmd.mul_en) begin
      prod_r <= mag_r * inv_sel;
    end
    if (cmd.chk_en) begin
      bad_r <= bad_r | axis_bad;
      acc_r <= acc_nxt;
    end
    if (cmd.addr_en) begin
      hit_r  <= !bad_r && (acc_r < ACC_DEPTH);
      cidx_r <= CELL_IDX_W'(acc_r);
    end
  end

  // Memory write selection: the clearing sweep, or the count update.
  assign mem_we = cmd.clr_step
                | (cmd.commit & hit_r & (is_add ? !cnt_max : is_clear));
  assign mem_waddr = cmd.clr_step ? clr_addr_r : cidx_r[AW-1:0];
  assign mem_wdata = (cmd.clr_step || !is_add) ? '0 : cnt_inc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[cidx_r[AW-1:0]];
  end

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r.out_of_range <= is_add & !hit_r;
      out_data_r.cell_index   <= (is_add && !hit_r) ? '0 : cidx_r;
      if (!hit_r) begin
        out_data_r.cell_count <= '0;
      end else if (is_add) begin
        out_data_r.cell_count <= CNT_OUT_W'(cnt_inc);
      end else begin
        out_data_r.cell_count <= CNT_OUT_W'(rdata_r);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.clr_last   = (clr_addr_r == CLR_LAST);
  assign sts.new_is_add = (in_data.command == CMD_ADD);
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

// File: rtl/uniform_grid_point_binning.sv
// Top level of the uniform grid point binning block: controller plus datapath.
//
//   Channel  Direction  Handshake                Payload
//   in_      input      in_valid / in_stall      in_item_t (command, pos, read_cell)
//   out_     output     out_valid / out_stall    out_item_t (index, count, flag)
//   cfg_     input      cfg_we                   cfg_index, cfg_wdata
//
// An add point, once accepted, steps through three axes of subtract, multiply
// and check through one shared 32x32 multiplier, then an address step, a
// registered memory read and the write-back, which waits for a free result
// register. A read or read-and-clear steps through accept, memory read and
// write-back. After reset a clearing pass zeroes the count memory, one entry
// per cycle, min(GRID_X*GRID_Y*GRID_Z, 32768) entries; in_stall is high meanwhile.
// The result register lets the next item be accepted while a result waits.
`default_nettype none

module uniform_grid_point_binning #(
  parameter int GRID_X     = ugpb_pkg::GRID_X_DEF,
  parameter int GRID_Y     = ugpb_pkg::GRID_Y_DEF,
  parameter int GRID_Z     = ugpb_pkg::GRID_Z_DEF,
  parameter int COUNT_BITS = ugpb_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [ugpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ugpb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire ugpb_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output ugpb_pkg::out_item_t                  out_data
);
  import ugpb_pkg::*;

  bin_cmd_t cmd;
  bin_sts_t sts;

  ugpb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  ugpb_dpath #(
    .GRID_X     (GRID_X),
    .GRID_Y     (GRID_Y),
    .GRID_Z     (GRID_Z),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // A result is only written into a free result register.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("result committed over a pending result");

  // A commit always presents a result in the next cycle.
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  // No item is accepted while the clearing pass runs.
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> in_stall)
    else $error("input accepted during clearing pass");

  // An out-of-range point reports index zero and count zero.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_of_range) |->
      (out_data.cell_index == '0 && out_data.cell_count == '0))
    else $error("out-of-range result carries nonzero fields");

endmodule

`default_nettype wire
